[rtl/core/epll_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants for the enhanced pll sine tracker
// no dependencies

package epll_pkg;

  localparam int PHASE_BITS_DEF  = 32;
  localparam int TABLE_BITS_DEF  = 10;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int GAIN_W    = 24;
  localparam int AMP_GAIN_SH = 20;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_AMP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_FREQ  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_PHASE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_STEP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FOLD_NEG   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TRUE_STEP  = 3'd5;

  localparam longint unsigned PI_Q30 = 64'd3373259426;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SIN,
    ST_COS,
    ST_CAPC,
    ST_LOAD,
    ST_MUL,
    ST_POST,
    ST_FREQ,
    ST_OUT
  } state_t;

  // multiply order: amplitude times sine, error products, then gain products
  typedef enum logic [2:0] {
    OP_AS,
    OP_ES,
    OP_EC,
    OP_GA,
    OP_GP,
    OP_GF
  } op_t;

endpackage

[rtl/core/enhanced_pll_sine_tracker.sv]
`timescale 1ns / 1ps
// enhanced pll sine tracker: amplitude, phase and frequency estimation per word
// a quarter-wave sine rom and one bit-serial shift-add multiplier shared by all products
// depends on epll_pkg
//
// One input word at a time is processed. All six products (amplitude times sine, error
// times sine and cosine, and the three gain products) run through a single shift-add
// multiplier that consumes one multiplier bit per cycle. A new word is accepted only after
// the result of the last one has been written to the output register. A finished result
// waits in the output register while the next input word is accepted and processed.
// Configuration registers are to be written only while no word is in flight; the block
// itself does not enforce this. Writing start_step also reloads the frequency state.

module enhanced_pll_sine_tracker #(
  parameter int PHASE_BITS  = epll_pkg::PHASE_BITS_DEF,
  parameter int TABLE_BITS  = epll_pkg::TABLE_BITS_DEF,
  parameter int SAMPLE_BITS = epll_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [SAMPLE_BITS-1:0]          in_sample,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [SAMPLE_BITS+1:0]          out_error,
  output logic signed [SAMPLE_BITS+1:0]          out_amplitude,
  output logic        [PHASE_BITS-1:0]           out_phase,
  output logic signed [PHASE_BITS:0]             out_freq_est,
  input  logic                                   cfg_we,
  input  logic [epll_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [((PHASE_BITS > epll_pkg::GAIN_W) ? PHASE_BITS : epll_pkg::GAIN_W)-1:0]
                                                 cfg_wdata
);
  import epll_pkg::*;

  localparam int PB    = PHASE_BITS;
  localparam int TB    = TABLE_BITS;
  localparam int SW    = SAMPLE_BITS;
  localparam int F     = SW - 1;
  localparam int AW    = SW + 2;
  localparam int BW    = AW + 1;
  localparam int AWID  = (AW > GAIN_W + 1) ? AW : GAIN_W + 1;
  localparam int PW    = AWID + BW;
  localparam int LW    = PW + PB + 2;
  localparam int FW    = PB + 3;
  localparam int CW    = $clog2(BW + 1);
  localparam int QSIZE = 1 << TB;
  localparam int RAW   = TB + 1;

  typedef logic [SW-1:0] rom_t [0:QSIZE];

  function automatic longint unsigned div_u64(input longint unsigned n,
                                              input longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic rom_t build_rom();
    rom_t t;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint s;
    for (int i = 0; i <= QSIZE; i++) begin
      x = (PI_Q30 * longint'(i) + (64'd1 << TB)) >> (TB + 1);
      x2 = (x * x + (64'd1 << 29)) >> 30;
      term = x;
      s = longint'(x);
      for (int k = 1; k <= 12; k++) begin
        term = div_u64((term * x2) >> 30, 64'((2 * k) * (2 * k + 1)));
        if (k[0]) begin
          s = s - longint'(term);
        end else begin
          s = s + longint'(term);
        end
      end
      if (s < 0) s = 0;
      if (s > (64'sd1 <<< 30)) s = 64'sd1 <<< 30;
      t[i] = SW'((longint'(s) + (64'd1 << (29 - F))) >> (30 - F));
    end
    return t;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  localparam logic signed [LW-1:0] AW_HI = $signed({{(LW-AW+1){1'b0}}, {(AW-1){1'b1}}});
  localparam logic signed [LW-1:0] AW_LO = $signed({{(LW-AW+1){1'b1}}, {(AW-1){1'b0}}});
  localparam logic signed [LW-1:0] PB_HI = $signed({{(LW-PB+1){1'b0}}, {(PB-1){1'b1}}});
  localparam logic signed [LW-1:0] PB_LO = $signed({{(LW-PB+1){1'b1}}, {(PB-1){1'b0}}});
  localparam logic signed [FW-1:0] FQ_HI = $signed({3'b000, {PB{1'b1}}});
  localparam logic signed [FW-1:0] FQ_LO = $signed({3'b111, {PB{1'b0}}});

  function automatic logic signed [AW-1:0] sat_aw(input logic signed [LW-1:0] v);
    logic signed [LW-1:0] c;
    c = (v > AW_HI) ? AW_HI : ((v < AW_LO) ? AW_LO : v);
    return c[AW-1:0];
  endfunction

  function automatic logic signed [PB-1:0] sat_pb(input logic signed [LW-1:0] v);
    logic signed [LW-1:0] c;
    c = (v > PB_HI) ? PB_HI : ((v < PB_LO) ? PB_LO : v);
    return c[PB-1:0];
  endfunction

  // configuration
  logic [GAIN_W-1:0] gain_amp_r, gain_freq_r, gain_phase_r;
  logic [PB-2:0]     start_r;
  logic              fold_r;
  logic [PB-1:0]     true_r;

  // loop state
  logic signed [AW-1:0] amp_r;
  logic signed [PB-1:0] step_r;
  logic [PB-1:0]        phase_r;

  // per-word working registers
  state_t               state_r, state_nxt;
  op_t                  op_r, op_nxt;
  logic signed [SW-1:0] x_r;
  logic [SW-1:0]        rom_q_r;
  logic signed [SW:0]   sn_r, cs_r;
  logic signed [AW-1:0] e_r;
  logic signed [BW-1:0] es_r, ec_r;
  logic signed [FW-1:0] f_r;
  logic [PW-1:0]        acc_r, mc_r;
  logic [BW-1:0]        mp_r;
  logic [CW-1:0]        cnt_r;
  logic                 out_valid_r;

  // rom addressing
  logic [PB-1:0]   ph_sel;
  logic [1:0]      quad;
  logic [TB-1:0]   tidx;
  logic [RAW-1:0]  rom_addr;
  logic            neg_q;
  logic signed [SW:0] rom_signed;

  always_comb begin
    ph_sel = (state_r == ST_SIN) ? phase_r : phase_r + (PB'(1) << (PB - 2));
    quad = ph_sel[PB-1 -: 2];
    tidx = ph_sel[PB-3 -: TB];
    rom_addr = quad[0] ? RAW'(QSIZE) - RAW'(tidx) : RAW'(tidx);
  end

  always_ff @(posedge clk) begin
    rom_q_r <= SINE_ROM[rom_addr];
  end

  // sign of the word leaving the rom: sine quadrant in ST_COS, cosine quadrant in ST_CAPC
  always_comb begin
    neg_q = (state_r == ST_COS) ? phase_r[PB-1] : ph_sel[PB-1];
    rom_signed = neg_q ? -$signed({1'b0, rom_q_r}) : $signed({1'b0, rom_q_r});
  end

  // multiplier step and rounding
  logic [PW-1:0]          acc_nxt;
  logic                   mul_last;
  logic signed [PW:0]     acc_ext;
  logic signed [PW:0]     rnd;
  logic signed [PW-1:0]   mc_load;
  logic signed [BW-1:0]   mp_load;

  always_comb begin
    mul_last = (cnt_r == CW'(BW - 1));
    acc_nxt = acc_r;
    if (mp_r[0]) begin
      acc_nxt = mul_last ? acc_r - mc_r : acc_r + mc_r;
    end
    acc_ext = $signed({acc_r[PW-1], acc_r});
    if (op_r == OP_GA) begin
      rnd = (acc_ext + ((PW+1)'(1) <<< (AMP_GAIN_SH - 1))) >>> AMP_GAIN_SH;
    end else begin
      rnd = (acc_ext + ((PW+1)'(1) <<< (F - 1))) >>> F;
    end
  end

  always_comb begin
    case (op_r)
      OP_AS: begin
        mc_load = PW'(amp_r);
        mp_load = BW'(sn_r);
      end
      OP_ES: begin
        mc_load = PW'(e_r);
        mp_load = BW'(sn_r);
      end
      OP_EC: begin
        mc_load = PW'(e_r);
        mp_load = BW'(cs_r);
      end
      OP_GA: begin
        mc_load = $signed(PW'(gain_amp_r));
        mp_load = es_r;
      end
      OP_GP: begin
        mc_load = $signed(PW'(gain_phase_r));
        mp_load = ec_r;
      end
      default: begin
        mc_load = $signed(PW'(gain_freq_r));
        mp_load = ec_r;
      end
    endcase
  end

  // post-multiply arithmetic
  logic signed [LW-1:0] sum_e, sum_amp, sum_step, sum_ph;
  logic signed [FW-1:0] fd, fn, fs;

  always_comb begin
    sum_e    = LW'(x_r) - LW'(rnd);
    sum_amp  = LW'(amp_r) + LW'(rnd);
    sum_step = LW'(step_r) + LW'(rnd);
    sum_ph   = $signed(LW'(phase_r)) + LW'(step_r) + LW'(rnd);
    fd = FW'(step_r) - $signed(FW'(start_r));
    fn = fold_r ? -fd : fd;
    fs = fn + $signed(FW'(true_r));
  end

  // state machine
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      op_r <= OP_AS;
    end else begin
      state_r <= state_nxt;
      op_r <= op_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt = op_r;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = ST_SIN;
          op_nxt = OP_AS;
        end
      end
      ST_SIN:  state_nxt = ST_COS;
      ST_COS:  state_nxt = ST_CAPC;
      ST_CAPC: state_nxt = ST_LOAD;
      ST_LOAD: state_nxt = ST_MUL;
      ST_MUL: begin
        if (mul_last) state_nxt = ST_POST;
      end
      ST_POST: begin
        state_nxt = ST_LOAD;
        unique case (op_r)
          OP_AS: op_nxt = OP_ES;
          OP_ES: op_nxt = OP_EC;
          OP_EC: op_nxt = OP_GA;
          OP_GA: op_nxt = OP_GP;
          OP_GP: op_nxt = OP_GF;
          default: state_nxt = ST_FREQ;
        endcase
      end
      ST_FREQ: state_nxt = ST_OUT;
      ST_OUT: begin
        if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // configuration and loop state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_amp_r <= '0;
      gain_freq_r <= '0;
      gain_phase_r <= '0;
      start_r <= '0;
      fold_r <= 1'b0;
      true_r <= '0;
      amp_r <= '0;
      step_r <= '0;
      phase_r <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_GAIN_AMP:   gain_amp_r <= cfg_wdata[GAIN_W-1:0];
          REG_GAIN_FREQ:  gain_freq_r <= cfg_wdata[GAIN_W-1:0];
          REG_GAIN_PHASE: gain_phase_r <= cfg_wdata[GAIN_W-1:0];
          REG_START_STEP: begin
            start_r <= cfg_wdata[PB-2:0];
            step_r <= $signed({1'b0, cfg_wdata[PB-2:0]});
          end
          REG_FOLD_NEG:   fold_r <= cfg_wdata[0];
          REG_TRUE_STEP:  true_r <= cfg_wdata[PB-1:0];
          default: ;
        endcase
      end
      if (state_r == ST_POST) begin
        case (op_r)
          OP_GA: amp_r <= sat_aw(sum_amp);
          OP_GP: phase_r <= sum_ph[PB-1:0];
          OP_GF: step_r <= sat_pb(sum_step);
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) x_r <= in_sample;
    if (state_r == ST_COS) sn_r <= rom_signed;
    if (state_r == ST_CAPC) cs_r <= rom_signed;
    if (state_r == ST_LOAD) begin
      acc_r <= '0;
      mc_r <= mc_load;
      mp_r <= mp_load;
      cnt_r <= '0;
    end else if (state_r == ST_MUL) begin
      acc_r <= acc_nxt;
      mc_r <= {mc_r[PW-2:0], 1'b0};
      mp_r <= {1'b0, mp_r[BW-1:1]};
      cnt_r <= cnt_r + CW'(1);
    end
    if (state_r == ST_POST) begin
      case (op_r)
        OP_AS: e_r <= sat_aw(sum_e);
        OP_ES: es_r <= rnd[BW-1:0];
        OP_EC: ec_r <= rnd[BW-1:0];
        default: ;
      endcase
    end
    if (state_r == ST_FREQ) begin
      f_r <= (fs > FQ_HI) ? FQ_HI : ((fs < FQ_LO) ? FQ_LO : fs);
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_OUT && (!out_valid_r || out_ready)) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_OUT && (!out_valid_r || out_ready)) begin
      out_error <= e_r;
      out_amplitude <= amp_r;
      out_phase <= phase_r;
      out_freq_est <= f_r[PB:0];
    end
  end

  assign out_valid = out_valid_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted twice in a row");

  a_phase_update: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$stable(phase_r) |-> $past(state_r == ST_POST && op_r == OP_GP))
    else $error("phase changed outside its update step");

  a_mul_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MUL |-> cnt_r < CW'(BW))
    else $error("multiplier bit count out of range");

endmodule

[tb/epll_tracker_checker.sv]
`timescale 1ns / 1ps
// result checker for the enhanced pll sine tracker: predicts every result word
// from accepted samples and register writes, compares field by field
// depends on epll_pkg

module epll_tracker_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [15:0] in_sample,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [17:0] out_error,
  input  logic signed [17:0] out_amplitude,
  input  logic        [31:0] out_phase,
  input  logic signed [32:0] out_freq_est,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata,
  output int                 fail_count,
  output int                 pending_count
);
  import epll_pkg::*;

  typedef struct {
    logic signed [17:0] err;
    logic signed [17:0] amp;
    logic [31:0]        ph;
    logic signed [32:0] freq;
  } track_word_t;

  track_word_t tracked_q[$];
  longint quarter_sine[0:1024];
  longint g_amp, g_freq, g_phase, start_step, true_step;
  bit fold_neg;
  longint amp_est, step_est;
  longint unsigned phase_acc;

  function automatic longint rshift_round(longint v, int sh);
    longint t;
    t = v + (longint'(1) << (sh - 1));
    return t >>> sh;
  endfunction

  function automatic longint clamp(longint v, int w);
    longint hi, lo;
    hi = (longint'(1) << (w - 1)) - 1;
    lo = -hi - 1;
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  function automatic longint sine_of(longint unsigned ph);
    longint unsigned q, idx;
    longint mag;
    q = (ph >> 30) & 3;
    idx = (ph >> 20) & 1023;
    mag = q[0] ? quarter_sine[1024 - idx] : quarter_sine[idx];
    return q[1] ? -mag : mag;
  endfunction

  initial begin
    longint unsigned x, x2, term;
    longint s;
    for (int i = 0; i <= 1024; i++) begin
      x = (PI_Q30 * i + 1024) >> 11;
      x2 = (x * x + (64'd1 << 29)) >> 30;
      term = x;
      s = x;
      for (int k = 1; k <= 12; k++) begin
        term = ((term * x2) >> 30) / ((2 * k) * (2 * k + 1));
        if (k % 2) s -= term; else s += term;
      end
      if (s < 0) s = 0;
      if (s > (longint'(1) << 30)) s = longint'(1) << 30;
      quarter_sine[i] = (s + (longint'(1) << 14)) >> 15;
    end
  end

  function automatic track_word_t track_sample(logic signed [15:0] smp);
    track_word_t r;
    longint sn, cs, e, es, ec, old_step, dph, f;
    sn = sine_of(phase_acc);
    cs = sine_of((phase_acc + 64'h4000_0000) & 64'hFFFF_FFFF);
    e = clamp(longint'(smp) - rshift_round(amp_est * sn, 15), 18);
    es = rshift_round(e * sn, 15);
    ec = rshift_round(e * cs, 15);
    old_step = step_est;
    amp_est = clamp(amp_est + rshift_round(g_amp * es, 20), 18);
    step_est = clamp(step_est + rshift_round(g_freq * ec, 15), 32);
    dph = rshift_round(g_phase * ec, 15);
    phase_acc = (phase_acc + old_step + dph) & 64'hFFFF_FFFF;
    f = step_est - start_step;
    if (fold_neg) f = -f;
    f = clamp(f + true_step, 33);
    r.err = e[17:0];
    r.amp = amp_est[17:0];
    r.ph = phase_acc[31:0];
    r.freq = f[32:0];
    return r;
  endfunction

  always_ff @(posedge clk) begin
    track_word_t exp_w;
    int errs;
    errs = 0;
    if (!rst_n) begin
      g_amp = 0; g_freq = 0; g_phase = 0; start_step = 0; true_step = 0;
      fold_neg = 0; amp_est = 0; step_est = 0; phase_acc = 0;
      fail_count <= 0;
      pending_count <= 0;
      tracked_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_GAIN_AMP:   g_amp = cfg_wdata[23:0];
          REG_GAIN_FREQ:  g_freq = cfg_wdata[23:0];
          REG_GAIN_PHASE: g_phase = cfg_wdata[23:0];
          REG_START_STEP: begin
            start_step = cfg_wdata[30:0];
            step_est = start_step;
          end
          REG_FOLD_NEG:   fold_neg = cfg_wdata[0];
          REG_TRUE_STEP:  true_step = cfg_wdata[31:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) tracked_q.push_back(track_sample(in_sample));
      if (out_valid && out_ready) begin
        if (tracked_q.size() == 0) begin
          $error("result word with none expected");
          errs = errs + 1;
        end else begin
          exp_w = tracked_q.pop_front();
          if (out_error !== exp_w.err) begin
            $error("error: expected %0d actual %0d", exp_w.err, out_error);
            errs = errs + 1;
          end
          if (out_amplitude !== exp_w.amp) begin
            $error("amplitude: expected %0d actual %0d", exp_w.amp, out_amplitude);
            errs = errs + 1;
          end
          if (out_phase !== exp_w.ph) begin
            $error("phase: expected %0h actual %0h", exp_w.ph, out_phase);
            errs = errs + 1;
          end
          if (out_freq_est !== exp_w.freq) begin
            $error("freq_est: expected %0d actual %0d", exp_w.freq, out_freq_est);
            errs = errs + 1;
          end
        end
      end
      fail_count <= fail_count + errs;
      pending_count <= tracked_q.size();
    end
  end
endmodule

[tb/tb_enhanced_pll_sine_tracker.sv]
`timescale 1ns / 1ps
// top testbench for the enhanced pll sine tracker: reset, register phases,
// sample stimulus with random gaps and stalls; checking lives in epll_tracker_checker
// depends on epll_pkg, enhanced_pll_sine_tracker and epll_tracker_checker

module tb_enhanced_pll_sine_tracker;
  import epll_pkg::*;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  logic signed [15:0] in_sample = 0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [17:0] out_error, out_amplitude;
  logic [31:0] out_phase;
  logic signed [32:0] out_freq_est;
  logic cfg_we = 0;
  logic [2:0] cfg_index = 0;
  logic [31:0] cfg_wdata = 0;
  int fail_count, pending_count;
  bit quiet_tail = 0;
  bit long_hold = 0;
  bit stim_done = 0;

  always #5 clk = ~clk;

  enhanced_pll_sine_tracker i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_sample(in_sample),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_error(out_error), .out_amplitude(out_amplitude),
    .out_phase(out_phase), .out_freq_est(out_freq_est),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  epll_tracker_checker i_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_sample(in_sample),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_error(out_error), .out_amplitude(out_amplitude),
    .out_phase(out_phase), .out_freq_est(out_freq_est),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  // receiver: random stall bursts, one long hold-off
  initial begin
    int n;
    @(posedge clk iff rst_n);
    forever begin
      if (long_hold) begin
        out_ready <= 0;
        repeat (600) @(posedge clk);
        long_hold = 0;
      end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        out_ready <= 0;
        n = $urandom_range(1, 15);
        repeat (n) @(posedge clk);
      end else begin
        out_ready <= 1;
        n = $urandom_range(1, 30);
        repeat (n) @(posedge clk);
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_we <= 1; cfg_index <= idx; cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  task automatic settle;
    in_valid <= 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic send_sample(input logic signed [15:0] v);
    int n;
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      in_valid <= 0;
      n = $urandom_range(1, 15);
      repeat (n) @(posedge clk);
    end
    in_valid <= 1; in_sample <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // sine-like sample with the given amplitude and random noise
  function automatic logic signed [15:0] tone(longint unsigned ph, int amp);
    real r;
    r = amp * $sin(6.283185307 * ph / 4294967296.0)
        + real'(int'($urandom_range(0, 600)) - 300);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return 16'($rtoi(r));
  endfunction

  task automatic run_phase(input int count, input longint unsigned st, input int amp);
    longint unsigned ph;
    ph = $urandom;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) < 8) send_sample(tone(ph, amp));
      else send_sample(16'($urandom));
      ph = (ph + st) & 64'hFFFF_FFFF;
    end
  endtask

  initial begin
    logic signed [15:0] edge_vals[6];
    longint unsigned st;
    edge_vals = '{16'sh7FFF, -16'sh8000, 0, 1, -1, 16'sh5555};
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed, all-zero registers then extremes
    foreach (edge_vals[i]) send_sample(edge_vals[i]);
    settle();
    write_reg(REG_GAIN_AMP, 32'hFFFFFF);
    write_reg(REG_GAIN_FREQ, 32'hFFFFFF);
    write_reg(REG_GAIN_PHASE, 32'hFFFFFF);
    write_reg(REG_START_STEP, 32'hFFFF_FFFF);
    write_reg(REG_FOLD_NEG, 32'hFFFF_FFFF);
    write_reg(REG_TRUE_STEP, 32'hFFFF_FFFF);
    write_reg(3'd6, 32'h1234);
    write_reg(3'd7, 32'h1234);
    for (int i = 0; i < 12; i++) send_sample(edge_vals[i % 6]);
    settle();
    // moderate tracking settings
    for (int p = 0; p < 5; p++) begin
      st = $urandom_range(1, 32'h0800_0000);
      write_reg(REG_GAIN_AMP, $urandom_range(0, 32'h8_0000));
      write_reg(REG_GAIN_FREQ, $urandom_range(0, 32'h400));
      write_reg(REG_GAIN_PHASE, $urandom_range(0, 32'h10_0000));
      write_reg(REG_START_STEP, st);
      write_reg(REG_FOLD_NEG, p % 2);
      write_reg(REG_TRUE_STEP, p == 2 ? 32'hFFFF_FFFF : $urandom);
      if (p == 1) long_hold = 1;
      if (p == 4) quiet_tail = 1;
      run_phase(p == 4 ? 110 : 150, st, $urandom_range(2000, 32767));
      settle();
    end
    stim_done = 1;
  end

  initial begin
    wait (stim_done);
    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end
endmodule
